// ----- rtl/ced_pkg.sv -----
// Shared types and constants of the container entry deframer.
// Holds the operation word passed from the parser to the emitter, the result
// kind and error codes, the container magic and the default queue depth.
package ced_pkg;

    // Result kinds as seen on the result port.
    localparam logic [1:0] KIND_PATH   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes reported when a container ends early or is malformed.
    localparam logic [2:0] ERR_SHORT_MAGIC  = 3'd0;
    localparam logic [2:0] ERR_BAD_MAGIC    = 3'd1;
    localparam logic [2:0] ERR_SHORT_LENGTH = 3'd2;
    localparam logic [2:0] ERR_SHORT_PATH   = 3'd3;
    localparam logic [2:0] ERR_SHORT_SIZE   = 3'd4;
    localparam logic [2:0] ERR_SHORT_DATA   = 3'd5;

    // The four magic bytes that open every entry: "PCK2".
    localparam logic [7:0] MAGIC [4] = '{8'h50, 8'h43, 8'h4B, 8'h32};

    // Default depth of the queue between parser and emitter.
    localparam int QUEUE_DEPTH = 4;

    // One parsed byte's worth of results: an optional echoed path byte,
    // followed by an optional record or error report.
    typedef struct packed {
        logic        path_vld;
        logic [7:0]  path_byte;
        logic        tail_vld;
        logic        tail_err;
        logic [2:0]  err_code;
        logic        done;
        logic        is_dir;
        logic [15:0] path_length;
        logic [63:0] file_size;
    } ced_op_t;

endpackage

// ----- rtl/ced_parser.sv -----
// Front end of the container entry deframer: walks the entry fields one byte
// at a time and turns each accepted byte into at most one operation word.
// Depends on ced_pkg.
module ced_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             end_mark,
    output logic             op_vld,
    output ced_pkg::ced_op_t op
);

    typedef enum logic [5:0] {
        PH_MAGIC = 6'b000001,
        PH_TYPE  = 6'b000010,
        PH_LEN   = 6'b000100,
        PH_PATH  = 6'b001000,
        PH_SIZE  = 6'b010000,
        PH_DATA  = 6'b100000
    } phase_t;

    phase_t      phase_reg,       phase_next;
    logic [15:0] field_count_reg, field_count_next;
    logic        mismatch_reg,    mismatch_next;
    logic        dir_reg,         dir_next;
    logic [15:0] path_len_reg,    path_len_next;
    logic [63:0] size_reg,        size_next;
    logic [63:0] data_left_reg,   data_left_next;
    logic        failed_reg,      failed_next;

    logic [15:0] fc_inc;
    logic [15:0] len_full;
    logic [63:0] size_asm;
    logic [63:0] left_dec;
    logic        mm;
    logic        tail_vld;

    always_comb
    begin
        fc_inc   = field_count_reg + 16'd1;
        len_full = {data_byte, path_len_reg[7:0]};
        size_asm = size_reg | ({56'd0, data_byte} << {field_count_reg[2:0], 3'b000});
        left_dec = data_left_reg - 64'd1;
        mm       = mismatch_reg | (data_byte != ced_pkg::MAGIC[field_count_reg[1:0]]);

        phase_next       = phase_reg;
        field_count_next = field_count_reg;
        mismatch_next    = mismatch_reg;
        dir_next         = dir_reg;
        path_len_next    = path_len_reg;
        size_next        = size_reg;
        data_left_next   = data_left_reg;
        failed_next      = failed_reg;

        op       = '0;
        tail_vld = 1'b0;

        if (!failed_reg)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    dir_next         = (data_byte == 8'd1);
                    phase_next       = PH_LEN;
                    field_count_next = 16'd0;
                    if (end_mark)
                    begin
                        tail_vld    = 1'b1;
                        op.tail_err = 1'b1;
                        op.err_code = ced_pkg::ERR_SHORT_LENGTH;
                    end
                end
                PH_LEN:
                begin
                    if (field_count_reg == 16'd0)
                    begin
                        path_len_next    = {8'd0, data_byte};
                        field_count_next = 16'd1;
                        if (end_mark)
                        begin
                            tail_vld    = 1'b1;
                            op.tail_err = 1'b1;
                            op.err_code = ced_pkg::ERR_SHORT_LENGTH;
                        end
                    end
                    else
                    begin
                        path_len_next    = len_full;
                        field_count_next = 16'd0;
                        size_next        = 64'd0;
                        phase_next       = (len_full == 16'd0) ? PH_SIZE : PH_PATH;
                        if (end_mark)
                        begin
                            tail_vld    = 1'b1;
                            op.tail_err = 1'b1;
                            op.err_code = (len_full == 16'd0) ? ced_pkg::ERR_SHORT_SIZE
                                                              : ced_pkg::ERR_SHORT_PATH;
                        end
                    end
                end
                PH_PATH:
                begin
                    op.path_vld      = 1'b1;
                    op.path_byte     = data_byte;
                    field_count_next = fc_inc;
                    if (fc_inc >= path_len_reg)
                    begin
                        phase_next       = PH_SIZE;
                        field_count_next = 16'd0;
                        size_next        = 64'd0;
                        if (end_mark)
                        begin
                            tail_vld    = 1'b1;
                            op.tail_err = 1'b1;
                            op.err_code = ced_pkg::ERR_SHORT_SIZE;
                        end
                    end
                    else if (end_mark)
                    begin
                        tail_vld    = 1'b1;
                        op.tail_err = 1'b1;
                        op.err_code = ced_pkg::ERR_SHORT_PATH;
                    end
                end
                PH_SIZE:
                begin
                    size_next        = size_asm;
                    field_count_next = fc_inc;
                    if (fc_inc >= 16'd8)
                    begin
                        field_count_next = 16'd0;
                        if (size_asm == 64'd0)
                        begin
                            // An empty entry completes on its last size byte.
                            tail_vld       = 1'b1;
                            op.is_dir      = dir_reg;
                            op.path_length = path_len_reg;
                            op.file_size   = size_asm;
                            op.done        = end_mark;
                            phase_next     = PH_MAGIC;
                            mismatch_next  = 1'b0;
                        end
                        else
                        begin
                            data_left_next = size_asm;
                            phase_next     = PH_DATA;
                            if (end_mark)
                            begin
                                tail_vld    = 1'b1;
                                op.tail_err = 1'b1;
                                op.err_code = ced_pkg::ERR_SHORT_DATA;
                            end
                        end
                    end
                    else if (end_mark)
                    begin
                        tail_vld    = 1'b1;
                        op.tail_err = 1'b1;
                        op.err_code = ced_pkg::ERR_SHORT_SIZE;
                    end
                end
                PH_DATA:
                begin
                    data_left_next = left_dec;
                    if (left_dec == 64'd0)
                    begin
                        tail_vld         = 1'b1;
                        op.is_dir        = dir_reg;
                        op.path_length   = path_len_reg;
                        op.file_size     = size_reg;
                        op.done          = end_mark;
                        phase_next       = PH_MAGIC;
                        field_count_next = 16'd0;
                        mismatch_next    = 1'b0;
                    end
                    else if (end_mark)
                    begin
                        tail_vld    = 1'b1;
                        op.tail_err = 1'b1;
                        op.err_code = ced_pkg::ERR_SHORT_DATA;
                    end
                end
                default:
                begin
                    // Magic phase; the comparison is judged on the fourth byte.
                    mismatch_next    = mm;
                    field_count_next = fc_inc;
                    if (fc_inc >= 16'd4)
                    begin
                        field_count_next = 16'd0;
                        if (mm)
                        begin
                            tail_vld    = 1'b1;
                            op.tail_err = 1'b1;
                            op.err_code = ced_pkg::ERR_BAD_MAGIC;
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_TYPE;
                            if (end_mark)
                            begin
                                tail_vld    = 1'b1;
                                op.tail_err = 1'b1;
                                op.err_code = ced_pkg::ERR_SHORT_LENGTH;
                            end
                        end
                    end
                    else if (end_mark)
                    begin
                        tail_vld    = 1'b1;
                        op.tail_err = 1'b1;
                        op.err_code = ced_pkg::ERR_SHORT_MAGIC;
                    end
                end
            endcase
        end

        // Errors always end the container.
        if (op.tail_err)
        begin
            op.done = 1'b1;
        end
        op.tail_vld = tail_vld;

        // The final byte of a container returns everything to its reset values.
        if (end_mark)
        begin
            phase_next       = PH_MAGIC;
            field_count_next = 16'd0;
            mismatch_next    = 1'b0;
            dir_next         = 1'b0;
            path_len_next    = 16'd0;
            size_next        = 64'd0;
            data_left_next   = 64'd0;
            failed_next      = 1'b0;
        end

        op_vld = accept & (op.path_vld | tail_vld);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_MAGIC;
            field_count_reg <= 16'd0;
            mismatch_reg    <= 1'b0;
            dir_reg         <= 1'b0;
            path_len_reg    <= 16'd0;
            size_reg        <= 64'd0;
            data_left_reg   <= 64'd0;
            failed_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            field_count_reg <= field_count_next;
            mismatch_reg    <= mismatch_next;
            dir_reg         <= dir_next;
            path_len_reg    <= path_len_next;
            size_reg        <= size_next;
            data_left_reg   <= data_left_next;
            failed_reg      <= failed_next;
        end
    end

endmodule

// ----- rtl/ced_queue.sv -----
// Short first-in first-out queue of operation words between parser and emitter.
// Depends on ced_pkg for the word type.
module ced_queue
#(
    parameter int DEPTH = ced_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  ced_pkg::ced_op_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output ced_pkg::ced_op_t rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ced_pkg::ced_op_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    logic do_wr;
    logic do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/ced_emitter.sv -----
// Back end of the container entry deframer: expands each operation word into
// one or two result words and holds the oldest one in an output register.
// Depends on ced_pkg.
module ced_emitter
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_vld,
    input  ced_pkg::ced_op_t head,
    output logic             deq,
    input  logic             pop,
    output logic             empty,
    output logic [1:0]       kind,
    output logic [7:0]       path_byte,
    output logic             is_dir,
    output logic [15:0]      path_length,
    output logic [63:0]      file_size,
    output logic [2:0]       error_code,
    output logic             container_done,
    output logic             run_last
);

    logic        out_vld_reg,   out_vld_next;
    logic        sent_path_reg, sent_path_next;
    logic [1:0]  kind_reg,      kind_next;
    logic [7:0]  path_byte_reg, path_byte_next;
    logic        is_dir_reg,    is_dir_next;
    logic [15:0] path_len_reg,  path_len_next;
    logic [63:0] size_reg,      size_next;
    logic [2:0]  err_reg,       err_next;
    logic        done_reg,      done_next;
    logic        last_reg,      last_next;
    logic        load;

    assign load = ~out_vld_reg | pop;

    always_comb
    begin
        deq            = 1'b0;
        out_vld_next   = out_vld_reg;
        sent_path_next = sent_path_reg;
        kind_next      = ced_pkg::KIND_PATH;
        path_byte_next = 8'd0;
        is_dir_next    = 1'b0;
        path_len_next  = 16'd0;
        size_next      = 64'd0;
        err_next       = 3'd0;
        done_next      = 1'b0;
        last_next      = 1'b1;

        if (load)
        begin
            out_vld_next = head_vld;
            if (head_vld)
            begin
                if (head.path_vld && !sent_path_reg)
                begin
                    path_byte_next = head.path_byte;
                    last_next      = ~head.tail_vld;
                    if (head.tail_vld)
                    begin
                        sent_path_next = 1'b1;
                    end
                    else
                    begin
                        deq = 1'b1;
                    end
                end
                else
                begin
                    deq            = 1'b1;
                    sent_path_next = 1'b0;
                    done_next      = head.done;
                    if (head.tail_err)
                    begin
                        kind_next = ced_pkg::KIND_ERROR;
                        err_next  = head.err_code;
                    end
                    else
                    begin
                        kind_next     = ced_pkg::KIND_RECORD;
                        is_dir_next   = head.is_dir;
                        path_len_next = head.path_length;
                        size_next     = head.file_size;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg   <= 1'b0;
            sent_path_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg   <= out_vld_next;
            sent_path_reg <= sent_path_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_vld)
        begin
            kind_reg      <= kind_next;
            path_byte_reg <= path_byte_next;
            is_dir_reg    <= is_dir_next;
            path_len_reg  <= path_len_next;
            size_reg      <= size_next;
            err_reg       <= err_next;
            done_reg      <= done_next;
            last_reg      <= last_next;
        end
    end

    assign empty          = ~out_vld_reg;
    assign kind           = kind_reg;
    assign path_byte      = path_byte_reg;
    assign is_dir         = is_dir_reg;
    assign path_length    = path_len_reg;
    assign file_size      = size_reg;
    assign error_code     = err_reg;
    assign container_done = done_reg;
    assign run_last       = last_reg;

endmodule

// ----- rtl/container_entry_deframer_core.sv -----
// Top level of the container entry deframer.
// Instantiates ced_parser, ced_queue and ced_emitter; depends on ced_pkg.
//
// Usage: container bytes enter on the input queue interface (push, full,
// data_byte, end_mark), one byte per word, with end_mark set on the final
// byte. A byte is taken at a clock edge where push is high and full is low.
// Results leave on the output queue interface: while empty is low the oldest
// result word sits on kind, path_byte, is_dir, path_length, file_size,
// error_code, container_done and run_last, and pop takes it.
// Each byte gives zero, one or two result words: echoed path bytes, a record
// after an entry's data has passed, or an error report when the container
// ends early or its magic is wrong.
// Path: a result is written into the queue and then loaded into the output register.
// Throughput: one byte per cycle on input while full is low and one result per
// cycle on output while pop is high; a byte that gives two results holds its
// queue entry until its second result is loaded, which the queue absorbs.
// Reset: rst_n clears the parser to the start of an entry and empties the
// queue and the output register. When the receiver stalls, results collect
// in the queue and full rises once it holds QUEUE_DEPTH words.
module container_entry_deframer_core
#(
    parameter int QUEUE_DEPTH = ced_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_mark,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  path_byte,
    output logic        is_dir,
    output logic [15:0] path_length,
    output logic [63:0] file_size,
    output logic [2:0]  error_code,
    output logic        container_done,
    output logic        run_last
);

    logic             accept;
    logic             op_vld;
    ced_pkg::ced_op_t op;
    logic             q_full;
    logic             q_empty;
    ced_pkg::ced_op_t q_head;
    logic             q_deq;

    // The parser advances on every accepted byte; it only waits when the
    // queue cannot take another operation word.
    assign full   = q_full;
    assign accept = push & ~q_full;

    ced_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .end_mark  (end_mark),
        .op_vld    (op_vld),
        .op        (op)
    );

    ced_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (op_vld),
        .wr_data (op),
        .full    (q_full),
        .rd_en   (q_deq),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    // The emitter splits a two-result word into a path result and a tail result and
    // releases the queue entry only when its last result is loaded.
    ced_emitter u_emitter
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_vld       (~q_empty),
        .head           (q_head),
        .deq            (q_deq),
        .pop            (pop),
        .empty          (empty),
        .kind           (kind),
        .path_byte      (path_byte),
        .is_dir         (is_dir),
        .path_length    (path_length),
        .file_size      (file_size),
        .error_code     (error_code),
        .container_done (container_done),
        .run_last       (run_last)
    );

endmodule

// ----- sim/container_entry_deframer_core_tb.sv -----
// Self-checking testbench for container_entry_deframer_core.
// Feeds directed and random containers through the byte queue and checks every
// result word against a predictor of its own; depends on ced_pkg and the core.
module container_entry_deframer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ced_pkg::*;

    // The run is aborted once the cycle count reaches this limit.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int TAIL_CYCLES  = 20;
    localparam int REPORT_LIMIT = 50;

    // Parser phases, in the order the fields of an entry arrive.
    typedef enum logic [2:0] {
        ST_MAGIC,
        ST_TYPE,
        ST_LENGTH,
        ST_PATH,
        ST_SIZE,
        ST_DATA
    } parse_phase_t;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_ALTERNATE,
        RX_RANDOM,
        RX_LONG_STALL
    } rx_mode_t;

    // One result word as it appears on the output ports.
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  path_byte;
        logic        is_dir;
        logic [15:0] path_length;
        logic [63:0] file_size;
        logic [2:0]  error_code;
        logic        container_done;
        logic        run_last;
    } deframe_word_t;

    // One input word waiting to be sent. A held word is not offered until
    // every result word predicted so far has been taken by the receiver.
    typedef struct {
        logic [7:0] value;
        logic       last;
        bit         hold;
    } stream_byte_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'h00;
    logic        end_mark = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  path_byte;
    logic        is_dir;
    logic [15:0] path_length;
    logic [63:0] file_size;
    logic [2:0]  error_code;
    logic        container_done;
    logic        run_last;

    container_entry_deframer_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .end_mark       (end_mark),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .path_byte      (path_byte),
        .is_dir         (is_dir),
        .path_length    (path_length),
        .file_size      (file_size),
        .error_code     (error_code),
        .container_done (container_done),
        .run_last       (run_last)
    );

    always #5 clk = ~clk;

    // Words still to be sent, the container under construction, and the
    // result words the predictor expects, oldest first.
    stream_byte_t  send_q[$];
    logic [7:0]    cbuf[$];
    deframe_word_t expected_words[$];

    // Both counters move only by nonblocking assignment, so that either
    // clocked block sees the values from before the current edge.
    int predicted_cnt = 0;
    int popped_cnt    = 0;

    int mismatch_cnt  = 0;
    int bytes_sent    = 0;
    int path_seen     = 0;
    int records_seen  = 0;
    int errors_seen   = 0;
    int cycle_cnt     = 0;

    // Predictor state; it mirrors the reset values of the parser.
    parse_phase_t ps_phase    = ST_MAGIC;
    logic [15:0]  ps_count    = '0;
    logic         ps_mismatch = 1'b0;
    logic         ps_dir      = 1'b0;
    logic [15:0]  ps_len      = '0;
    logic [63:0]  ps_size     = '0;
    logic [63:0]  ps_left     = '0;
    logic         ps_failed   = 1'b0;

    // Sender and receiver pacing.
    int       burst_left = 0;
    int       gap_left   = 0;
    rx_mode_t rx_mode    = RX_STEADY;
    int       rx_left    = 0;
    int       stall_left = 0;
    bit       rx_toggle  = 1'b0;

    task automatic parser_clear();
        ps_phase    = ST_MAGIC;
        ps_count    = '0;
        ps_mismatch = 1'b0;
        ps_dir      = 1'b0;
        ps_len      = '0;
        ps_size     = '0;
        ps_left     = '0;
        ps_failed   = 1'b0;
    endtask

    function automatic deframe_word_t make_word(input logic [1:0] k, input logic [7:0] pb,
                                                input logic dir, input logic [15:0] len,
                                                input logic [63:0] size, input logic [2:0] err,
                                                input logic done);
        deframe_word_t w;
        w.kind           = k;
        w.path_byte      = pb;
        w.is_dir         = dir;
        w.path_length    = len;
        w.file_size      = size;
        w.error_code     = err;
        w.container_done = done;
        w.run_last       = 1'b0;
        return w;
    endfunction

    function automatic deframe_word_t error_word(input logic [2:0] code);
        return make_word(KIND_ERROR, 8'h00, 1'b0, 16'h0000, 64'h0, code, 1'b1);
    endfunction

    // Advances the predictor by one accepted byte and queues the result words
    // it causes; n returns how many were queued.
    task automatic deframe_byte(input logic [7:0] b, input logic e, output int n);
        deframe_word_t words[$];
        // Once the magic has failed, everything up to the end mark is dropped.
        if (!ps_failed) begin
            case (ps_phase)
                ST_TYPE: begin
                    ps_dir   = (b == 8'h01);
                    ps_phase = ST_LENGTH;
                    ps_count = '0;
                    // The end mark on the type byte leaves the length missing.
                    if (e) words.push_back(error_word(ERR_SHORT_LENGTH));
                end
                ST_LENGTH: begin
                    if (ps_count == 16'd0) begin
                        ps_len   = {8'h00, b};
                        ps_count = 16'd1;
                        if (e) words.push_back(error_word(ERR_SHORT_LENGTH));
                    end else begin
                        ps_len   = ps_len | {b, 8'h00};
                        ps_count = '0;
                        ps_size  = '0;
                        ps_phase = (ps_len == 16'd0) ? ST_SIZE : ST_PATH;
                        if (e) begin
                            words.push_back(error_word((ps_len == 16'd0) ? ERR_SHORT_SIZE
                                                                          : ERR_SHORT_PATH));
                        end
                    end
                end
                ST_PATH: begin
                    words.push_back(make_word(KIND_PATH, b, 1'b0, 16'h0000, 64'h0, 3'd0,
                                              1'b0));
                    ps_count = ps_count + 16'd1;
                    if (ps_count >= ps_len) begin
                        ps_phase = ST_SIZE;
                        ps_count = '0;
                        ps_size  = '0;
                        if (e) words.push_back(error_word(ERR_SHORT_SIZE));
                    end else if (e) begin
                        words.push_back(error_word(ERR_SHORT_PATH));
                    end
                end
                ST_SIZE: begin
                    ps_size  = ps_size | (64'(b) << {ps_count[2:0], 3'b000});
                    ps_count = ps_count + 16'd1;
                    if (ps_count >= 16'd8) begin
                        ps_count = '0;
                        if (ps_size == 64'h0) begin
                            // Nothing to skip: the record is due right away.
                            words.push_back(make_word(KIND_RECORD, 8'h00, ps_dir, ps_len,
                                                      ps_size, 3'd0, e));
                            ps_phase    = ST_MAGIC;
                            ps_mismatch = 1'b0;
                        end else begin
                            ps_left  = ps_size;
                            ps_phase = ST_DATA;
                            if (e) words.push_back(error_word(ERR_SHORT_DATA));
                        end
                    end else if (e) begin
                        words.push_back(error_word(ERR_SHORT_SIZE));
                    end
                end
                ST_DATA: begin
                    ps_left = ps_left - 64'd1;
                    if (ps_left == 64'h0) begin
                        words.push_back(make_word(KIND_RECORD, 8'h00, ps_dir, ps_len,
                                                  ps_size, 3'd0, e));
                        ps_phase    = ST_MAGIC;
                        ps_count    = '0;
                        ps_mismatch = 1'b0;
                    end else if (e) begin
                        words.push_back(error_word(ERR_SHORT_DATA));
                    end
                end
                default: begin
                    // The magic is judged as a whole on its fourth byte, so an
                    // early end reports a short magic even after a wrong byte.
                    if (b != MAGIC[ps_count[1:0]]) ps_mismatch = 1'b1;
                    ps_count = ps_count + 16'd1;
                    if (ps_count >= 16'd4) begin
                        ps_count = '0;
                        if (ps_mismatch) begin
                            words.push_back(error_word(ERR_BAD_MAGIC));
                            ps_failed = 1'b1;
                        end else begin
                            ps_phase = ST_TYPE;
                            if (e) words.push_back(error_word(ERR_SHORT_LENGTH));
                        end
                    end else if (e) begin
                        words.push_back(error_word(ERR_SHORT_MAGIC));
                    end
                end
            endcase
        end
        if (e) parser_clear();
        if (words.size() > 0) words[words.size() - 1].run_last = 1'b1;
        foreach (words[i]) expected_words.push_back(words[i]);
        n = words.size();
    endtask

    // Appends one entry to the container under construction. The length and
    // size fields may disagree with the bytes that follow, which is how the
    // truncated and malformed cases are built.
    task automatic add_entry(input logic [7:0] type_byte, input logic [15:0] len_field,
                             input int npath, input logic [63:0] size_field, input int ndata);
        for (int i = 0; i < 4; i++) cbuf.push_back(MAGIC[i]);
        cbuf.push_back(type_byte);
        cbuf.push_back(len_field[7:0]);
        cbuf.push_back(len_field[15:8]);
        for (int i = 0; i < npath; i++) cbuf.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < 8; i++) cbuf.push_back(size_field[8*i +: 8]);
        for (int i = 0; i < ndata; i++) cbuf.push_back(8'($urandom_range(0, 255)));
    endtask

    // Moves the container into the send queue, keeping only the first cut
    // bytes when cut is in range, and sets the end mark on its final byte.
    task automatic send_container(input int cut, input bit hold);
        int keep;
        keep = (cut <= 0 || cut > cbuf.size()) ? cbuf.size() : cut;
        for (int i = 0; i < keep; i++) begin
            send_q.push_back('{value: cbuf[i], last: (i == keep - 1), hold: (hold && i == 0)});
        end
        cbuf.delete();
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            if (mismatch_cnt < REPORT_LIMIT) begin
                $display("%0t: %s differs, expected %0h, actual %0h", $time, name, want, got);
            end
            mismatch_cnt++;
        end
    endtask

    // Sender. The byte on the ports is the head of send_q; it leaves the queue
    // at the edge where it is accepted, and the predictor sees it right then.
    always @(posedge clk or negedge rst_n) begin : sender
        int n_new;
        if (!rst_n) begin
            push      <= 1'b0;
            data_byte <= 8'h00;
            end_mark  <= 1'b0;
            parser_clear();
        end else begin
            n_new = 0;
            if (push && !full) begin
                deframe_byte(send_q[0].value, send_q[0].last, n_new);
                void'(send_q.pop_front());
                predicted_cnt <= predicted_cnt + n_new;
                bytes_sent++;
            end
            // A byte refused by a full queue stays on the ports unchanged.
            if (!push || !full) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (send_q.size() == 0 ||
                             (send_q[0].hold && predicted_cnt + n_new != popped_cnt)) begin
                    push <= 1'b0;
                end else begin
                    push      <= 1'b1;
                    data_byte <= send_q[0].value;
                    end_mark  <= send_q[0].last;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4: gap_left = 0;
                            9:             gap_left = $urandom_range(10, 30);
                            default:       gap_left = $urandom_range(1, 5);
                        endcase
                    end
                end
            end
        end
    end

    // Receiver. It checks each word it takes against the oldest expectation
    // and then picks the next pop from its current stall pattern.
    always @(posedge clk or negedge rst_n) begin : receiver
        deframe_word_t want;
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (popped_cnt == predicted_cnt) begin
                    if (mismatch_cnt < REPORT_LIMIT) begin
                        $display("%0t: unexpected result word, kind %0d", $time, kind);
                    end
                    mismatch_cnt++;
                end else begin
                    want = expected_words.pop_front();
                    compare_field("kind", want.kind, kind);
                    compare_field("path_byte", want.path_byte, path_byte);
                    compare_field("is_dir", want.is_dir, is_dir);
                    compare_field("path_length", want.path_length, path_length);
                    compare_field("file_size", want.file_size, file_size);
                    compare_field("error_code", want.error_code, error_code);
                    compare_field("container_done", want.container_done, container_done);
                    compare_field("run_last", want.run_last, run_last);
                    case (want.kind)
                        KIND_PATH:   path_seen++;
                        KIND_RECORD: records_seen++;
                        default:     errors_seen++;
                    endcase
                    popped_cnt <= popped_cnt + 1;
                end
            end
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 120);
            end
            rx_left--;
            case (rx_mode)
                RX_STEADY: pop <= 1'b1;
                RX_ALTERNATE: begin
                    rx_toggle = ~rx_toggle;
                    pop <= rx_toggle;
                end
                RX_RANDOM: pop <= ($urandom_range(0, 9) >= 3);
                default: begin
                    // Long stalls let the internal queue fill and push full.
                    if (stall_left > 0) begin
                        stall_left--;
                        pop <= 1'b0;
                    end else begin
                        pop <= 1'b1;
                        if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(5, 25);
                    end
                end
            endcase
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d bytes unsent and %0d results outstanding",
                     $time, send_q.size(), predicted_cnt - popped_cnt);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        int       style;
        int       nent;
        int       plen;
        int       dsize;
        int       cut;
        int       nnoise;
        int       target;
        bit       hold;
        bit       first;
        logic [15:0] len_field;
        logic [63:0] size_field;
        logic [7:0]  type_byte;

        rst_n = 1'b0;

        // A lone byte with the end mark: the magic is cut short even though
        // the byte is already wrong.
        cbuf = '{8'h00};
        send_container(0, 1'b0);
        // A wrong fourth magic byte fails the container; the bytes after it
        // up to the end mark give nothing.
        cbuf = '{MAGIC[0], MAGIC[1], MAGIC[2], 8'hFF, MAGIC[3], MAGIC[0]};
        send_container(0, 1'b0);
        // The end mark on the last magic byte leaves the type byte missing.
        cbuf = '{MAGIC[0], MAGIC[1], MAGIC[2], MAGIC[3]};
        send_container(0, 1'b0);
        // A directory with an empty path and zero size: the record comes on
        // the last size byte and closes the container.
        add_entry(8'h01, 16'h0000, 0, 64'h0, 0);
        send_container(0, 1'b0);

        // Random containers: mostly well formed, some cut short anywhere,
        // some with wild length and size fields, and some plain noise.
        target = send_q.size() + RANDOM_ITEMS;
        first  = 1'b1;
        while (send_q.size() < target) begin
            style = $urandom_range(0, 99);
            hold  = first || ($urandom_range(0, 39) == 0);
            first = 1'b0;
            if (style < 70) begin
                nent = $urandom_range(1, 3);
                for (int i = 0; i < nent; i++) begin
                    plen      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                    dsize     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    type_byte = $urandom_range(0, 1) ? 8'h01 : 8'($urandom_range(0, 255));
                    add_entry(type_byte, 16'(plen), plen, 64'(dsize), dsize);
                end
                cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cbuf.size()) : 0;
            end else if (style < 85) begin
                type_byte = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1)) begin
                    len_field = 16'($urandom_range(0, 65535));
                    plen      = $urandom_range(0, 5);
                end else begin
                    plen      = $urandom_range(0, 3);
                    len_field = 16'(plen);
                end
                size_field = {$urandom, $urandom};
                add_entry(type_byte, len_field, plen, size_field, $urandom_range(0, 3));
                cut = $urandom_range(1, cbuf.size());
            end else begin
                // Noise that often resembles the magic, so that the mismatch
                // lands on every one of the four positions.
                nnoise = $urandom_range(1, 8);
                for (int i = 0; i < nnoise; i++) begin
                    if ($urandom_range(0, 1)) cbuf.push_back(MAGIC[i % 4]);
                    else cbuf.push_back(8'($urandom_range(0, 255)));
                end
                cut = 0;
            end
            send_container(cut, hold);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sample on the falling edge, away from the clocked blocks.
        while (send_q.size() != 0 || push) @(negedge clk);
        while (popped_cnt != predicted_cnt) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d container bytes; checked %0d path bytes, %0d records, %0d errors.",
                 bytes_sent, path_seen, records_seen, errors_seen);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
